// ===== hdl/rbp_pkg.sv =====
// Shared types, constants, stage map and helpers for the Boris pusher.
// No dependencies; used by rbp_invgam and relativistic_boris_push_top.
`default_nettype none
package rbp_pkg;

  typedef logic signed [31:0] fix_t;

  typedef enum logic [1:0] {
    CFG_HALF_KICK = 2'd0,
    CFG_HALF_STEP = 2'd1,
    CFG_INV_C2    = 2'd2
  } cfg_idx_e;

  localparam int DIMENSION = 2;
  localparam int NUM_AX    = 2;

  localparam logic [16:0] ONE_Q16    = 17'h10000;
  localparam logic [48:0] GAM_LIMIT  = 49'h1_0000_0000_0000;  // 2^48
  localparam logic [33:0] DIV_NUM    = 34'h2_0000_0000;       // 2.0 in Q16.16 << 16

  localparam int GAM_BITS = 17;
  localparam int GAM_LAT  = 4 + GAM_BITS;
  localparam int DIV_BITS = 18;
  localparam int DIV_LAT  = DIV_BITS;

  // stage map, stages numbered from the input register (stage 0)
  localparam int ST_IN   = 0;
  localparam int ST_HE   = ST_IN + 1;
  localparam int ST_UM   = ST_HE + 1;
  localparam int ST_IG1  = ST_IN + GAM_LAT;
  localparam int ST_T1   = ST_IG1 + 1;
  localparam int ST_DP1  = ST_T1 + 1;
  localparam int ST_POS1 = ST_DP1 + 1;
  localparam int ST_GM   = ST_UM + GAM_LAT;
  localparam int ST_KP   = ST_GM + 1;
  localparam int ST_K    = ST_KP + 1;
  localparam int ST_BK   = ST_K + 1;
  localparam int ST_TAU  = ST_BK + 1;
  localparam int ST_CP1  = ST_TAU + 1;
  localparam int ST_CD1  = ST_CP1 + 1;
  localparam int ST_UD   = ST_CD1 + 1;
  localparam int ST_CP2  = ST_UD + 1;
  localparam int ST_UR   = ST_CP2 + 1;
  localparam int ST_F    = ST_UD + DIV_LAT;
  localparam int ST_FU   = ST_F + 1;
  localparam int ST_U2   = ST_FU + 1;
  localparam int ST_IG2  = ST_U2 + GAM_LAT;
  localparam int ST_T2   = ST_IG2 + 1;
  localparam int ST_DP2  = ST_T2 + 1;
  localparam int ST_POS2 = ST_DP2 + 1;
  localparam int ST_LAST = ST_POS2;
  localparam int OUT_LAT = ST_LAST + 2;

  function automatic fix_t sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rbp_invgam.sv =====
// Pipelined 1/gamma: sum of squares, scale by 1/c^2, then one result bit per stage.
// Depends on rbp_pkg.
`default_nettype none
module rbp_invgam
  import rbp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire fix_t        mom_i [3],
  input  wire logic [30:0] ilc_i,
  output logic      [16:0] ig_o
);

  logic [62:0] sq_q [3];
  logic [63:0] s_q;
  logic [62:0] ph_q, pl_q;
  logic [63:0] w_full;
  logic [48:0] w_q;

  logic [16:0] r_q [GAM_BITS];
  logic [48:0] p_q [GAM_BITS];
  logic [48:0] a_q [GAM_BITS];
  logic [48:0] wl_q [GAM_BITS];
  logic [16:0] r_d [GAM_BITS];
  logic [48:0] p_d [GAM_BITS];
  logic [48:0] a_d [GAM_BITS];
  logic signed [63:0] sq_full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = mom_i[i] * mom_i[i];
    end
    w_full = 64'(ONE_Q16) + 64'(ph_q) + 64'(pl_q[62:32]);
  end

  // Greedy search for the largest r with r*r*w <= 2^48. P = r*r*w and
  // A = r*w are kept so a trial needs only shifts and adds.
  always_comb begin
    logic [16:0] rp;
    logic [48:0] pp, ap, wp;
    logic [83:0] pc;
    int b;
    for (int j = 0; j < GAM_BITS; j++) begin
      b  = GAM_BITS - 1 - j;
      rp = (j == 0) ? '0 : r_q[(j == 0) ? 0 : j - 1];
      pp = (j == 0) ? '0 : p_q[(j == 0) ? 0 : j - 1];
      ap = (j == 0) ? '0 : a_q[(j == 0) ? 0 : j - 1];
      wp = (j == 0) ? w_q : wl_q[(j == 0) ? 0 : j - 1];
      pc = 84'(pp) + (84'(ap) << (b + 1)) + (84'(wp) << (2 * b));
      if (pc <= 84'(GAM_LIMIT)) begin
        r_d[j] = rp | (17'd1 << b);
        p_d[j] = pc[48:0];
        a_d[j] = 49'(84'(ap) + (84'(wp) << b));
      end else begin
        r_d[j] = rp;
        p_d[j] = pp;
        a_d[j] = ap;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= sq_full[i][62:0];
    end
    s_q  <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    ph_q <= s_q[63:32] * ilc_i;
    pl_q <= s_q[31:0] * ilc_i;
    // anything above 2^48 gives zero; clamp keeps the search narrow
    w_q  <= (w_full > 64'(GAM_LIMIT)) ? GAM_LIMIT + 49'd1 : w_full[48:0];
    for (int j = 0; j < GAM_BITS; j++) begin
      r_q[j]  <= r_d[j];
      p_q[j]  <= p_d[j];
      a_q[j]  <= a_d[j];
      wl_q[j] <= (j == 0) ? w_q : wl_q[(j == 0) ? 0 : j - 1];
    end
  end

  assign ig_o = r_q[GAM_BITS - 1];

endmodule
`default_nettype wire

// ===== hdl/relativistic_boris_push_top.sv =====
// Relativistic Boris pusher, 2D position, 3D momentum, Q16.16 position and momentum.
// Depends on rbp_pkg and rbp_invgam.
//
// One particle beat is taken in every cycle that start_i is high (busy_o is
// always low) and its result appears on done_o in order, for one cycle; the
// receiver has no way to stall. The pipeline holds three 21-stage 1/gamma
// units (one result bit per stage) and an 18-stage restoring divider for
// 2/(1+|tau|^2), all in one fixed pipeline. Both kinds of beat take the same
// path length. Write configuration only while no beat is in flight.
`default_nettype none
module relativistic_boris_push_top
  import rbp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        kind_i,
  input  wire fix_t        pos_x_i,
  input  wire fix_t        pos_y_i,
  input  wire fix_t        mom_x_i,
  input  wire fix_t        mom_y_i,
  input  wire fix_t        mom_z_i,
  input  wire fix_t        efield_x_i,
  input  wire fix_t        efield_y_i,
  input  wire fix_t        efield_z_i,
  input  wire fix_t        bfield_x_i,
  input  wire fix_t        bfield_y_i,
  input  wire fix_t        bfield_z_i,
  output logic             done_o,
  output fix_t             new_pos_x_o,
  output fix_t             new_pos_y_o,
  output fix_t             new_mom_x_o,
  output fix_t             new_mom_y_o,
  output fix_t             new_mom_z_o,
  output logic [16:0]      inv_gamma_o
);

  // configuration
  fix_t        hkf_q;
  logic [30:0] hts_q, ilc_q;

  // control
  logic vld_q  [ST_IN:ST_LAST];
  logic done_q;

  // data pipeline
  logic  kind_q [ST_IN:ST_LAST];
  fix_t  pos_q  [ST_IN:ST_DP1][NUM_AX];
  fix_t  u_q    [ST_IN:ST_LAST][3];
  fix_t  e_q    [3];
  fix_t  b_q    [ST_IN:ST_K][3];
  logic signed [63:0] he_q [3];
  logic signed [47:0] h_q  [ST_UM:ST_FU][3];
  fix_t  um_q   [ST_UM:ST_FU][3];

  logic [16:0] ig1_w, gm_w, ig2_w;
  logic [16:0] ig1_q [ST_T1:ST_LAST];
  logic [16:0] ig2_q [ST_T2:ST_LAST];

  logic [47:0] t1_full, t2_full;
  logic [30:0] t1_q, t2_q;
  logic signed [63:0] dp1_q [NUM_AX];
  logic signed [63:0] dp2_q [NUM_AX];
  fix_t  pos1_q [ST_POS1:ST_LAST][NUM_AX];
  fix_t  pos2_q [NUM_AX];

  logic signed [48:0] kp_q;
  fix_t  k_q;
  logic signed [63:0] bk_q [3];
  fix_t  tau_q  [ST_TAU:ST_UD][3];
  logic signed [63:0] tsq_full [3];
  logic [62:0] tsq_q [3];
  logic [63:0] ts_q;
  logic [48:0] den_q;
  logic signed [63:0] cpa1_q [3], cpb1_q [3];
  logic signed [64:0] cd1_q [3];
  fix_t  ud_q [3];
  logic signed [63:0] cpa2_q [3], cpb2_q [3];
  fix_t  ur_q [ST_UR:ST_F][3];
  logic signed [50:0] fu_q [3];
  fix_t  u2_q [ST_U2:ST_LAST][3];

  // divider for f = 2^33 / den
  logic [17:0] dq_q [DIV_BITS];
  logic [33:0] dr_q [DIV_BITS];
  logic [48:0] dd_q [DIV_BITS];
  logic [17:0] dq_d [DIV_BITS];
  logic [33:0] dr_d [DIV_BITS];
  logic [17:0] f_w;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hkf_q <= '0;
      hts_q <= 31'd32768;
      ilc_q <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HALF_KICK: hkf_q <= cfg_wdata_i;
        CFG_HALF_STEP: hts_q <= cfg_wdata_i[30:0];
        CFG_INV_C2:    ilc_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = ST_IN; s <= ST_LAST; s++) begin
        vld_q[s] <= 1'b0;
      end
      done_q <= 1'b0;
    end else begin
      vld_q[ST_IN] <= start_i && !busy_o;
      for (int s = ST_IN + 1; s <= ST_LAST; s++) begin
        vld_q[s] <= vld_q[s - 1];
      end
      done_q <= vld_q[ST_LAST];
    end
  end

  rbp_invgam u_gam_in (
    .clk_i (clk_i),
    .mom_i (u_q[ST_IN]),
    .ilc_i (ilc_q),
    .ig_o  (ig1_w)
  );

  rbp_invgam u_gam_mid (
    .clk_i (clk_i),
    .mom_i (um_q[ST_UM]),
    .ilc_i (ilc_q),
    .ig_o  (gm_w)
  );

  rbp_invgam u_gam_out (
    .clk_i (clk_i),
    .mom_i (u2_q[ST_U2]),
    .ilc_i (ilc_q),
    .ig_o  (ig2_w)
  );

  assign t1_full = hts_q * ig1_w;
  assign t2_full = hts_q * ig2_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsq_full[i] = tau_q[ST_TAU][i] * tau_q[ST_TAU][i];
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [17:0] qp;
    logic [33:0] rp;
    logic [48:0] dp;
    logic [66:0] trial;
    int b;
    for (int j = 0; j < DIV_BITS; j++) begin
      b  = DIV_BITS - 1 - j;
      qp = (j == 0) ? '0 : dq_q[(j == 0) ? 0 : j - 1];
      rp = (j == 0) ? DIV_NUM : dr_q[(j == 0) ? 0 : j - 1];
      dp = (j == 0) ? den_q : dd_q[(j == 0) ? 0 : j - 1];
      trial = 67'(dp) << b;
      if (trial <= 67'(rp)) begin
        dq_d[j] = qp | (18'd1 << b);
        dr_d[j] = rp - trial[33:0];
      end else begin
        dq_d[j] = qp;
        dr_d[j] = rp;
      end
    end
  end

  assign f_w = dq_q[DIV_BITS - 1];

  always_ff @(posedge clk_i) begin
    // input beat
    kind_q[ST_IN]    <= kind_i;
    pos_q[ST_IN][0]  <= pos_x_i;
    pos_q[ST_IN][1]  <= pos_y_i;
    u_q[ST_IN][0]    <= mom_x_i;
    u_q[ST_IN][1]    <= mom_y_i;
    u_q[ST_IN][2]    <= mom_z_i;
    e_q[0]           <= efield_x_i;
    e_q[1]           <= efield_y_i;
    e_q[2]           <= efield_z_i;
    b_q[ST_IN][0]    <= bfield_x_i;
    b_q[ST_IN][1]    <= bfield_y_i;
    b_q[ST_IN][2]    <= bfield_z_i;

    // delay lines
    for (int s = ST_IN + 1; s <= ST_LAST; s++) begin
      kind_q[s] <= kind_q[s - 1];
      u_q[s]    <= u_q[s - 1];
    end
    for (int s = ST_IN + 1; s <= ST_DP1; s++) pos_q[s] <= pos_q[s - 1];
    for (int s = ST_IN + 1; s <= ST_K; s++) b_q[s] <= b_q[s - 1];
    for (int s = ST_UM + 1; s <= ST_FU; s++) begin
      h_q[s]  <= h_q[s - 1];
      um_q[s] <= um_q[s - 1];
    end
    ig1_q[ST_T1] <= ig1_w;
    for (int s = ST_T1 + 1; s <= ST_LAST; s++) ig1_q[s] <= ig1_q[s - 1];
    ig2_q[ST_T2] <= ig2_w;
    for (int s = ST_T2 + 1; s <= ST_LAST; s++) ig2_q[s] <= ig2_q[s - 1];
    for (int s = ST_POS1 + 1; s <= ST_LAST; s++) pos1_q[s] <= pos1_q[s - 1];
    for (int s = ST_TAU + 1; s <= ST_UD; s++) tau_q[s] <= tau_q[s - 1];
    for (int s = ST_UR + 1; s <= ST_F; s++) ur_q[s] <= ur_q[s - 1];
    for (int s = ST_U2 + 1; s <= ST_LAST; s++) u2_q[s] <= u2_q[s - 1];

    // half electric impulse
    for (int i = 0; i < 3; i++) begin
      he_q[i]        <= e_q[i] * hkf_q;
      h_q[ST_UM][i]  <= 48'(he_q[i] >>> 16);
      um_q[ST_UM][i] <= sat32(64'(u_q[ST_HE][i]) + (he_q[i] >>> 16));
    end

    // first half drift
    t1_q <= t1_full[46:16];
    for (int a = 0; a < NUM_AX; a++) begin
      dp1_q[a] <= u_q[ST_T1][a] * $signed({1'b0, t1_q});
      pos1_q[ST_POS1][a] <= (a < DIMENSION)
                          ? sat32(64'(pos_q[ST_DP1][a]) + (dp1_q[a] >>> 16))
                          : pos_q[ST_DP1][a];
    end

    // rotation vector tau = B * 2*k/gamma
    kp_q <= hkf_q * $signed({1'b0, gm_w});
    k_q  <= sat32(64'(kp_q >>> 15));
    for (int i = 0; i < 3; i++) begin
      bk_q[i]          <= b_q[ST_K][i] * k_q;
      tau_q[ST_TAU][i] <= sat32(bk_q[i] >>> 16);
      tsq_q[i]         <= tsq_full[i][62:0];
    end
    ts_q  <= 64'(tsq_q[0]) + 64'(tsq_q[1]) + 64'(tsq_q[2]);
    den_q <= 49'(ONE_Q16) + 49'(ts_q >> 16);

    // u' = u- + u- x tau ; ur = u' x tau
    for (int i = 0; i < 3; i++) begin
      cpa1_q[i] <= um_q[ST_TAU][(i + 1) % 3] * tau_q[ST_TAU][(i + 2) % 3];
      cpb1_q[i] <= um_q[ST_TAU][(i + 2) % 3] * tau_q[ST_TAU][(i + 1) % 3];
      cd1_q[i]  <= 65'(cpa1_q[i]) - 65'(cpb1_q[i]);
      ud_q[i]   <= sat32(64'(um_q[ST_CD1][i]) + 64'(cd1_q[i] >>> 16));
      cpa2_q[i] <= ud_q[(i + 1) % 3] * tau_q[ST_UD][(i + 2) % 3];
      cpb2_q[i] <= ud_q[(i + 2) % 3] * tau_q[ST_UD][(i + 1) % 3];
      ur_q[ST_UR][i] <= sat32(64'((65'(cpa2_q[i]) - 65'(cpb2_q[i])) >>> 16));
    end

    for (int j = 0; j < DIV_BITS; j++) begin
      dq_q[j] <= dq_d[j];
      dr_q[j] <= dr_d[j];
      dd_q[j] <= (j == 0) ? den_q : dd_q[(j == 0) ? 0 : j - 1];
    end

    // u+ = u- + f*ur + second half impulse
    for (int i = 0; i < 3; i++) begin
      fu_q[i] <= $signed({1'b0, f_w}) * ur_q[ST_F][i];
      u2_q[ST_U2][i] <= sat32(64'(um_q[ST_FU][i]) + 64'(fu_q[i] >>> 16)
                              + 64'(h_q[ST_FU][i]));
    end

    // second half drift
    t2_q <= t2_full[46:16];
    for (int a = 0; a < NUM_AX; a++) begin
      dp2_q[a]  <= u2_q[ST_DP1 - ST_T1 + ST_T2 - 1][a] * $signed({1'b0, t2_q});
      pos2_q[a] <= (a < DIMENSION)
                 ? sat32(64'(pos1_q[ST_DP2][a]) + (dp2_q[a] >>> 16))
                 : pos1_q[ST_DP2][a];
    end

    // result beat
    if (kind_q[ST_LAST]) begin
      new_pos_x_o <= pos2_q[0];
      new_pos_y_o <= pos2_q[1];
      new_mom_x_o <= u2_q[ST_LAST][0];
      new_mom_y_o <= u2_q[ST_LAST][1];
      new_mom_z_o <= u2_q[ST_LAST][2];
      inv_gamma_o <= ig2_q[ST_LAST];
    end else begin
      new_pos_x_o <= pos1_q[ST_LAST][0];
      new_pos_y_o <= pos1_q[ST_LAST][1];
      new_mom_x_o <= u_q[ST_LAST][0];
      new_mom_y_o <= u_q[ST_LAST][1];
      new_mom_z_o <= u_q[ST_LAST][2];
      inv_gamma_o <= ig1_q[ST_LAST];
    end
  end

  assign done_o = done_q;

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start_i && !busy_o && rst_ni, OUT_LAT))
    else $error("result beat does not match an accepted beat");

  a_inv_gamma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (inv_gamma_o <= 17'(ONE_Q16)))
    else $error("inv_gamma above one");

  a_drift_keeps_mom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(kind_i, OUT_LAT)) |->
      (new_mom_x_o == $past(mom_x_i, OUT_LAT) &&
       new_mom_z_o == $past(mom_z_i, OUT_LAT)))
    else $error("drift-only beat changed momentum");

endmodule
`default_nettype wire

// ===== tb/relativistic_boris_push_top_tb.sv =====
// Testbench for relativistic_boris_push_top: drives particle beats in bursts
// and with random gaps, predicts each push in a local model and checks
// results in order. Depends on rbp_pkg and the RTL of the pusher.
`timescale 1ns / 100ps
`default_nettype none
module relativistic_boris_push_top_tb;
  import rbp_pkg::*;

  localparam int PIPE_WAIT = 100;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic kind;
    fix_t px, py, ux, uy, uz, ex, ey, ez, bx, by, bz;
  } particle_t;

  typedef struct packed {
    fix_t px, py, ux, uy, uz;
    logic [16:0] ig;
  } pushed_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  particle_t drv = '0;
  logic done_o;
  fix_t new_pos_x_o, new_pos_y_o, new_mom_x_o, new_mom_y_o, new_mom_z_o;
  logic [16:0] inv_gamma_o;

  // model copy of the registers
  longint kick_fac = 0;
  longint half_dt = 32768;
  longint inv_c2 = 65536;

  pushed_t pushed_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_kick = 0;
  int idle_cycles = 0;
  bit burst_mode = 1'b1;

  relativistic_boris_push_top uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i, .busy_o,
    .kind_i(drv.kind), .pos_x_i(drv.px), .pos_y_i(drv.py),
    .mom_x_i(drv.ux), .mom_y_i(drv.uy), .mom_z_i(drv.uz),
    .efield_x_i(drv.ex), .efield_y_i(drv.ey), .efield_z_i(drv.ez),
    .bfield_x_i(drv.bx), .bfield_y_i(drv.by), .bfield_z_i(drv.bz),
    .done_o, .new_pos_x_o, .new_pos_y_o, .new_mom_x_o, .new_mom_y_o,
    .new_mom_z_o, .inv_gamma_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint fl_shr(longint v, int n);
    return v >>> n;  // arithmetic shift is floor
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint recip_gamma(longint a, longint b, longint c);
    logic [63:0] s, w, r, cand;
    s = 64'(a * a) + 64'(b * b) + 64'(c * c);
    w = 64'd65536 + (s >> 32) * 64'(inv_c2) + (((s & 64'hFFFF_FFFF) * 64'(inv_c2)) >> 32);
    r = '0;
    for (int bi = 16; bi >= 0; bi--) begin
      cand = r | (64'd1 << bi);
      if (w <= (64'd1 << 48) / (cand * cand)) r = cand;
    end
    return longint'(r);
  endfunction

  function automatic pushed_t push_particle(particle_t p);
    longint pos[2], u[3], e[3], bf[3], h[3], um[3], tau[3], cr[3], ud[3], ur[3];
    longint ig, t, gm, k, f;
    logic [63:0] ts;
    pushed_t r;
    pos[0] = longint'(p.px); pos[1] = longint'(p.py);
    u[0] = longint'(p.ux); u[1] = longint'(p.uy); u[2] = longint'(p.uz);
    e[0] = longint'(p.ex); e[1] = longint'(p.ey); e[2] = longint'(p.ez);
    bf[0] = longint'(p.bx); bf[1] = longint'(p.by); bf[2] = longint'(p.bz);
    ig = recip_gamma(u[0], u[1], u[2]);
    t = longint'((64'(half_dt) * 64'(ig)) >> 16);
    for (int a = 0; a < DIMENSION; a++) pos[a] = clamp32(pos[a] + fl_shr(u[a] * t, 16));
    if (p.kind) begin
      for (int i = 0; i < 3; i++) begin
        h[i] = fl_shr(kick_fac * e[i], 16);
        um[i] = clamp32(u[i] + h[i]);
      end
      gm = recip_gamma(um[0], um[1], um[2]);
      k = clamp32(fl_shr(2 * kick_fac * gm, 16));
      for (int i = 0; i < 3; i++) tau[i] = clamp32(fl_shr(bf[i] * k, 16));
      ts = 64'(tau[0] * tau[0]) + 64'(tau[1] * tau[1]) + 64'(tau[2] * tau[2]);
      f = longint'((64'd1 << 33) / (64'd65536 + (ts >> 16)));
      cr[0] = fl_shr(um[1] * tau[2] - um[2] * tau[1], 16);
      cr[1] = fl_shr(um[2] * tau[0] - um[0] * tau[2], 16);
      cr[2] = fl_shr(um[0] * tau[1] - um[1] * tau[0], 16);
      for (int i = 0; i < 3; i++) ud[i] = clamp32(um[i] + cr[i]);
      cr[0] = fl_shr(ud[1] * tau[2] - ud[2] * tau[1], 16);
      cr[1] = fl_shr(ud[2] * tau[0] - ud[0] * tau[2], 16);
      cr[2] = fl_shr(ud[0] * tau[1] - ud[1] * tau[0], 16);
      for (int i = 0; i < 3; i++) begin
        ur[i] = clamp32(cr[i]);
        u[i] = clamp32(um[i] + fl_shr(f * ur[i], 16) + h[i]);
      end
      ig = recip_gamma(u[0], u[1], u[2]);
      t = longint'((64'(half_dt) * 64'(ig)) >> 16);
      for (int a = 0; a < DIMENSION; a++) pos[a] = clamp32(pos[a] + fl_shr(u[a] * t, 16));
    end
    r.px = fix_t'(pos[0]); r.py = fix_t'(pos[1]);
    r.ux = fix_t'(u[0]); r.uy = fix_t'(u[1]); r.uz = fix_t'(u[2]);
    r.ig = ig[16:0];
    return r;
  endfunction

  // ---------------- checker ----------------
  task automatic cmp_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pushed_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        pushed_t x;
        x = pushed_q.pop_front();
        cmp_field("new_pos_x", longint'(x.px), longint'(new_pos_x_o));
        cmp_field("new_pos_y", longint'(x.py), longint'(new_pos_y_o));
        cmp_field("new_mom_x", longint'(x.ux), longint'(new_mom_x_o));
        cmp_field("new_mom_y", longint'(x.uy), longint'(new_mom_y_o));
        cmp_field("new_mom_z", longint'(x.uz), longint'(new_mom_z_o));
        cmp_field("inv_gamma", longint'(x.ig), longint'(inv_gamma_o));
        n_checked++;
      end
    end
  end

  // watchdog: cycles without any beat accepted on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("FAIL relativistic_boris_push_top");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_particle(particle_t p);
    int gap;
    if (!burst_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (burst_mode && $urandom_range(0, 15) == 0) burst_mode = 1'b0;
    else if (!burst_mode && $urandom_range(0, 7) == 0) burst_mode = 1'b1;
    start_i <= 1'b1;
    drv <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pushed_q.push_back(push_particle(p));
    if (p.kind) n_kick++;
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (pushed_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_WAIT) @(negedge clk_i);
  endtask

  // one register write per cycle; cfg_release ends a run of writes
  task automatic write_reg(cfg_idx_e idx, longint val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[31:0];
    @(negedge clk_i);
    case (idx)
      CFG_HALF_KICK: kick_fac = longint'(signed'(val[31:0]));
      CFG_HALF_STEP: half_dt = val & 64'h7FFF_FFFF;
      default: inv_c2 = val & 64'h7FFF_FFFF;
    endcase
  endtask

  task automatic cfg_release;
    cfg_we_i <= 1'b0;
  endtask

  function automatic fix_t rnd_fix(int scale);
    case (scale)
      0: return $urandom;
      1: return fix_t'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
      default: return fix_t'($signed($urandom_range(0, 32'h0060_0000)) - 32'sh0030_0000);
    endcase
  endfunction

  function automatic particle_t rnd_particle(int scale);
    particle_t p;
    p.kind = ($urandom_range(0, 3) != 0);
    p.px = $urandom; p.py = $urandom;
    p.ux = rnd_fix(scale); p.uy = rnd_fix(scale); p.uz = rnd_fix(scale);
    p.ex = rnd_fix(scale); p.ey = rnd_fix(scale); p.ez = rnd_fix(scale);
    p.bx = rnd_fix(scale); p.by = rnd_fix(scale); p.bz = rnd_fix(scale);
    if ($urandom_range(0, 15) == 0) p = p ^ {1'b0, {11{32'h8000_0000}}};
    return p;
  endfunction

  task automatic test_reset_config;
    particle_t p;
    p = '0;
    send_particle(p);
    p.kind = 1'b1;
    p.ux = 32'sh0001_0000; p.ex = 32'sh0000_8000; p.bz = 32'sh0001_0000;
    send_particle(p);
    drain();
  endtask

  task automatic test_directed;
    particle_t p;
    fix_t ext[4];
    ext = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0, -32'sh1};
    write_reg(CFG_HALF_KICK, 32'sh0000_4000);
    write_reg(CFG_HALF_STEP, 32'h0001_0000);
    write_reg(CFG_INV_C2, 32'h0000_0100);
    cfg_release();
    for (int i = 0; i < 4; i++) begin
      p = {1'b0, {11{ext[i]}}};
      send_particle(p);
      p.kind = 1'b1;
      send_particle(p);
      p = {1'b1, ext[i], ext[3 - i], ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4],
           ext[3 - i], ext[i], ext[(i + 3) % 4], ext[i], ext[(i + 1) % 4], ext[3 - i]};
      send_particle(p);
    end
    // strong field: large tau, divisor far above one
    p = '0;
    p.kind = 1'b1; p.ux = 32'sh0002_0000; p.bz = 32'sh0100_0000; p.bx = -32'sh0080_0000;
    send_particle(p);
    drain();
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_particle(rnd_particle($urandom_range(0, 2)));
  endtask

  task automatic test_config_sweep;
    longint kicks[5], steps[4], c2s[4];
    kicks = '{-64'sd2147483648, 64'sd2147483647, 64'sd0, 64'sd32768, -64'sd6554};
    steps = '{64'd0, 64'h7FFF_FFFF, 64'd32768, 64'd3277};
    c2s = '{64'd0, 64'h7FFF_FFFF, 64'd65536, 64'd1};
    for (int s = 0; s < 8; s++) begin
      write_reg(CFG_HALF_KICK, kicks[s % 5]);
      write_reg(CFG_HALF_STEP, steps[s % 4]);
      write_reg(CFG_INV_C2, c2s[(s + s / 4) % 4]);
      cfg_release();
      run_random(100);
      drain();
    end
  endtask

  task automatic test_random_config;
    for (int s = 0; s < 5; s++) begin
      write_reg(CFG_HALF_KICK, $urandom);
      write_reg(CFG_HALF_STEP, $urandom & 32'h7FFF_FFFF);
      write_reg(CFG_INV_C2, $urandom_range(0, 32'h0002_0000));
      cfg_release();
      run_random(90);
      drain();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_config();
    test_directed();
    test_config_sweep();
    test_random_config();
    $display("Pushed %0d particles (%0d with Boris kick), %0d results checked,",
             n_sent, n_kick, n_checked);
    $display("over extreme and random settings of all three registers.");
    if (errors == 0 && pushed_q.size() == 0) begin
      $display("PASS relativistic_boris_push_top");
    end else begin
      $display("FAIL relativistic_boris_push_top");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
hdl/rbp_pkg.sv
hdl/rbp_invgam.sv
hdl/relativistic_boris_push_top.sv
tb/relativistic_boris_push_top_tb.sv
